### hw/rtl/pba_pkg.sv
// Shared constants, codes and controller/datapath link types of the page bitmap allocator.
`timescale 1ns / 1ps

package pba_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_COUNT = 65536;

    localparam int ADDR_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STAT_W    = 2;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int OFF_W     = $clog2(PAGE_BYTES);
    localparam int MAP_WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = $clog2(MAP_WORDS);
    localparam int CNT_W     = $clog2(PAGE_COUNT) + 1;
    localparam int PG_W      = ((ADDR_W + 2 - OFF_W) > (CNT_W + 1)) ?
                               (ADDR_W + 2 - OFF_W) : (CNT_W + 1);

    typedef enum logic [KIND_W-1:0] {
        K_CLEAR     = 3'd0,
        K_QUERY     = 3'd1,
        K_MARK_FREE = 3'd2,
        K_MARK_USED = 3'd3,
        K_ALLOC     = 3'd4,
        K_FREE      = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_NORUN  = 2'd1,
        ST_BADARG = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_DECODE,
        S_CLR,
        S_Q_RD,
        S_Q_EV,
        S_M_RD,
        S_M_WR,
        S_A_RD,
        S_A_EV,
        S_A_BIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic take_req;
        logic clr_res;
        logic set_bad;
        logic set_norun;
        logic set_range;
        logic set_qidx;
        logic widx_zero;
        logic widx_inc;
        logic rd_en;
        logic wr_zero;
        logic wr_mask;
        logic q_latch;
        logic scan_eval;
        logic bit_step;
        logic alloc_hit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              unaligned;
        logic              q_oor;
        logic              sa_ge_ea;
        logic              range_empty;
        logic              need_zero;
        logic              word_last;
        logic              mark_last;
        logic              word_skip;
        logic              bit_found;
        logic              bit_last;
    } t_dp_stat;

endpackage

### hw/rtl/pba_if.sv
// Request and response channel interfaces of the page bitmap allocator.
`timescale 1ns / 1ps

interface pba_req_if;
    logic                        valid;
    logic                        ready;
    logic [pba_pkg::KIND_W-1:0]  kind;
    logic [pba_pkg::ADDR_W-1:0]  start_address;
    logic [pba_pkg::ADDR_W-1:0]  end_address;
    logic [pba_pkg::ADDR_W-1:0]  byte_size;

    modport source (output valid, kind, start_address, end_address, byte_size, input ready);
    modport sink   (input valid, kind, start_address, end_address, byte_size, output ready);
endinterface

interface pba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        available;
    logic [pba_pkg::ADDR_W-1:0]  result_address;
    logic [pba_pkg::STAT_W-1:0]  status;

    modport source (output valid, available, result_address, status, input ready);
    modport sink   (input valid, available, result_address, status, output ready);
endinterface

### hw/rtl/pba_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### hw/rtl/pba_dp.sv
// Datapath: request registers, page range math, bitmap RAM, run scan and result registers.
`timescale 1ns / 1ps

module pba_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pba_pkg::t_dp_cmd            i_cmd,
    output pba_pkg::t_dp_stat           o_stat,
    input  logic [pba_pkg::KIND_W-1:0]  i_kind,
    input  logic [pba_pkg::ADDR_W-1:0]  i_start_address,
    input  logic [pba_pkg::ADDR_W-1:0]  i_end_address,
    input  logic [pba_pkg::ADDR_W-1:0]  i_byte_size,
    output logic                        o_available,
    output logic [pba_pkg::ADDR_W-1:0]  o_result_address,
    output logic [pba_pkg::STAT_W-1:0]  o_status
);
    localparam int AW  = pba_pkg::ADDR_W;
    localparam int PW  = pba_pkg::PG_W;
    localparam int CW  = pba_pkg::CNT_W;
    localparam int WW  = pba_pkg::WIDX_W;
    localparam int OW  = pba_pkg::OFF_W;
    localparam int DW  = pba_pkg::WORD_W;
    localparam int BW  = pba_pkg::BIT_W;

    logic [pba_pkg::KIND_W-1:0] r_kind;
    logic [AW-1:0]              r_sa, r_ea, r_sz;
    logic [CW-1:0]              r_lo, r_hi;
    logic                       r_val;
    logic [WW-1:0]              r_widx;
    logic [DW-1:0]              r_word;
    logic [BW-1:0]              r_bit;
    logic [PW-1:0]              r_run_len;
    logic [CW-1:0]              r_run_start;
    logic                       r_avail;
    logic [AW-1:0]              r_addr;
    logic [pba_pkg::STAT_W-1:0] r_status;
    logic                       r_o_avail;
    logic [AW-1:0]              r_o_addr;
    logic [pba_pkg::STAT_W-1:0] r_o_status;

    logic [DW-1:0] rdata, merged, mask, masked_rd, wdata;
    logic [PW-1:0] sa_page, sa_up, ea_past, need, free_past, pc, lo_raw, hi_raw, hi_cl;
    logic [CW-1:0] hi_m1, base, cur_page, found_start;
    logic [BW-1:0] lo_bit, hi_bit;
    logic          is_free, mark_last, word_zero, word_ones, skip_ones, cur_bit;

    assign pc        = PW'(pba_pkg::PAGE_COUNT);
    assign sa_page   = PW'(r_sa[AW-1:OW]);
    assign sa_up     = PW'(({1'b0, r_sa} + (AW+1)'(pba_pkg::PAGE_BYTES - 1)) >> OW);
    assign ea_past   = PW'(({1'b0, r_ea} + (AW+1)'(1)) >> OW);
    assign need      = PW'(({1'b0, r_sz} + (AW+1)'(pba_pkg::PAGE_BYTES - 1)) >> OW);
    assign free_past = sa_page + need;
    assign is_free   = (r_kind == pba_pkg::K_FREE);
    assign lo_raw    = is_free ? sa_page : sa_up;
    assign hi_raw    = is_free ? free_past : ea_past;
    assign hi_cl     = (hi_raw > pc) ? pc : hi_raw;

    // Bit mask of the current word that falls inside [lo, hi).
    assign hi_m1     = r_hi - CW'(1);
    assign mark_last = (r_widx == WW'(hi_m1 >> BW));
    assign lo_bit    = (r_widx == WW'(r_lo >> BW)) ? r_lo[BW-1:0] : '0;
    assign hi_bit    = mark_last ? hi_m1[BW-1:0] : BW'(DW - 1);
    assign mask      = ({DW{1'b1}} << lo_bit) & ({DW{1'b1}} >> (BW'(DW - 1) - hi_bit));
    assign merged    = r_val ? (rdata | mask) : (rdata & ~mask);
    assign wdata     = i_cmd.wr_zero ? '0 : merged;

    // Page 0 never takes part in a search.
    assign masked_rd = rdata & ~((r_widx == '0) ? DW'(1) : DW'(0));
    assign word_zero = (masked_rd == '0);
    assign word_ones = &masked_rd;
    assign skip_ones = word_ones && ((r_run_len + PW'(DW)) < need);
    assign base      = CW'({r_widx, {BW{1'b0}}});
    assign cur_page  = CW'({r_widx, r_bit});
    assign cur_bit   = r_word[r_bit];
    assign found_start = (r_run_len == '0) ? cur_page : r_run_start;

    assign o_stat.kind        = r_kind;
    assign o_stat.unaligned   = (r_sa[OW-1:0] != '0);
    assign o_stat.q_oor       = (sa_page >= pc);
    assign o_stat.sa_ge_ea    = (r_sa >= r_ea);
    assign o_stat.range_empty = (lo_raw >= hi_cl);
    assign o_stat.need_zero   = (need == '0);
    assign o_stat.word_last   = (r_widx == WW'(pba_pkg::MAP_WORDS - 1));
    assign o_stat.mark_last   = mark_last;
    assign o_stat.word_skip   = word_zero || skip_ones;
    assign o_stat.bit_found   = cur_bit && ((r_run_len + PW'(1)) == need);
    assign o_stat.bit_last    = (r_bit == BW'(DW - 1));

    pba_ram #(
        .WIDTH (DW),
        .DEPTH (pba_pkg::MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_zero || i_cmd.wr_mask),
        .i_wr_addr (r_widx),
        .i_wr_data (wdata),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_widx),
        .o_rd_data (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
        end else if (i_cmd.widx_zero) begin
            r_widx <= '0;
        end else if (i_cmd.set_range) begin
            r_widx <= WW'(lo_raw >> BW);
        end else if (i_cmd.set_qidx) begin
            r_widx <= WW'(sa_page >> BW);
        end else if (i_cmd.alloc_hit) begin
            r_widx <= WW'(found_start >> BW);
        end else if (i_cmd.widx_inc) begin
            r_widx <= r_widx + WW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_kind <= i_kind;
            r_sa   <= i_start_address;
            r_ea   <= i_end_address;
            r_sz   <= i_byte_size;
        end
        if (i_cmd.set_range) begin
            r_lo  <= CW'(lo_raw);
            r_hi  <= CW'(hi_cl);
            r_val <= (r_kind == pba_pkg::K_MARK_FREE) || is_free;
        end else if (i_cmd.alloc_hit) begin
            r_lo  <= found_start;
            r_hi  <= CW'(PW'(found_start) + need);
            r_val <= 1'b0;
        end
        if (i_cmd.widx_zero) begin
            r_run_len <= '0;
        end else if (i_cmd.scan_eval) begin
            if (word_zero) begin
                r_run_len <= '0;
            end else if (skip_ones) begin
                if (r_run_len == '0) begin
                    r_run_start <= base;
                end
                r_run_len <= r_run_len + PW'(DW);
            end
        end else if (i_cmd.bit_step) begin
            if (!cur_bit) begin
                r_run_len <= '0;
            end else begin
                if (r_run_len == '0) begin
                    r_run_start <= cur_page;
                end
                r_run_len <= r_run_len + PW'(1);
            end
        end
        if (i_cmd.scan_eval) begin
            r_word <= masked_rd;
            r_bit  <= '0;
        end else if (i_cmd.bit_step) begin
            r_bit <= r_bit + BW'(1);
        end
        if (i_cmd.clr_res) begin
            r_avail <= 1'b0;
            r_addr  <= '0;
        end else if (i_cmd.q_latch) begin
            r_avail <= rdata[r_sa[OW+BW-1:OW]];
        end else if (i_cmd.alloc_hit) begin
            r_addr <= AW'({found_start, {OW{1'b0}}});
        end
        // An error code raised at decode lands together with the clear of the result.
        if (i_cmd.set_bad) begin
            r_status <= pba_pkg::ST_BADARG;
        end else if (i_cmd.set_norun) begin
            r_status <= pba_pkg::ST_NORUN;
        end else if (i_cmd.clr_res) begin
            r_status <= pba_pkg::ST_OK;
        end
        if (i_cmd.out_load) begin
            r_o_avail  <= r_avail;
            r_o_addr   <= r_addr;
            r_o_status <= r_status;
        end
    end

    assign o_available      = r_o_avail;
    assign o_result_address = r_o_addr;
    assign o_status         = r_o_status;
endmodule

### hw/rtl/pba_ctrl.sv
// Controller: request sequencing state machine and channel handshakes.
`timescale 1ns / 1ps

module pba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    input  pba_pkg::t_dp_stat  i_stat,
    output pba_pkg::t_dp_cmd   o_cmd
);
    pba_pkg::t_state  r_state, n_state;
    logic             r_out_valid;
    pba_pkg::t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pba_pkg::S_BOOT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        o_req_ready = 1'b0;
        case (r_state)
            pba_pkg::S_BOOT: begin
                cmd.wr_zero = 1'b1;
                if (i_stat.word_last) begin
                    cmd.widx_zero = 1'b1;
                    n_state       = pba_pkg::S_IDLE;
                end else begin
                    cmd.widx_inc = 1'b1;
                end
            end
            pba_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    cmd.take_req = 1'b1;
                    n_state      = pba_pkg::S_DECODE;
                end
            end
            pba_pkg::S_DECODE: begin
                cmd.clr_res = 1'b1;
                n_state     = pba_pkg::S_RESP;
                case (i_stat.kind)
                    pba_pkg::K_CLEAR: begin
                        cmd.widx_zero = 1'b1;
                        n_state       = pba_pkg::S_CLR;
                    end
                    pba_pkg::K_QUERY: begin
                        if (i_stat.unaligned) begin
                            cmd.set_bad = 1'b1;
                        end else if (!i_stat.q_oor) begin
                            cmd.set_qidx = 1'b1;
                            n_state      = pba_pkg::S_Q_RD;
                        end
                    end
                    pba_pkg::K_MARK_FREE, pba_pkg::K_MARK_USED: begin
                        if (i_stat.sa_ge_ea) begin
                            cmd.set_bad = 1'b1;
                        end else if (!i_stat.range_empty) begin
                            cmd.set_range = 1'b1;
                            n_state       = pba_pkg::S_M_RD;
                        end
                    end
                    pba_pkg::K_FREE: begin
                        if (i_stat.unaligned) begin
                            cmd.set_bad = 1'b1;
                        end else if (!i_stat.range_empty) begin
                            cmd.set_range = 1'b1;
                            n_state       = pba_pkg::S_M_RD;
                        end
                    end
                    pba_pkg::K_ALLOC: begin
                        if (i_stat.need_zero) begin
                            cmd.set_norun = 1'b1;
                        end else begin
                            cmd.widx_zero = 1'b1;
                            n_state       = pba_pkg::S_A_RD;
                        end
                    end
                    default: begin
                        cmd.set_bad = 1'b1;
                    end
                endcase
            end
            pba_pkg::S_CLR: begin
                cmd.wr_zero = 1'b1;
                if (i_stat.word_last) begin
                    cmd.widx_zero = 1'b1;
                    n_state       = pba_pkg::S_RESP;
                end else begin
                    cmd.widx_inc = 1'b1;
                end
            end
            pba_pkg::S_Q_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = pba_pkg::S_Q_EV;
            end
            pba_pkg::S_Q_EV: begin
                cmd.q_latch = 1'b1;
                n_state     = pba_pkg::S_RESP;
            end
            pba_pkg::S_M_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = pba_pkg::S_M_WR;
            end
            pba_pkg::S_M_WR: begin
                cmd.wr_mask = 1'b1;
                if (i_stat.mark_last) begin
                    n_state = pba_pkg::S_RESP;
                end else begin
                    cmd.widx_inc = 1'b1;
                    n_state      = pba_pkg::S_M_RD;
                end
            end
            pba_pkg::S_A_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = pba_pkg::S_A_EV;
            end
            pba_pkg::S_A_EV: begin
                cmd.scan_eval = 1'b1;
                if (!i_stat.word_skip) begin
                    n_state = pba_pkg::S_A_BIT;
                end else if (i_stat.word_last) begin
                    cmd.set_norun = 1'b1;
                    n_state       = pba_pkg::S_RESP;
                end else begin
                    cmd.widx_inc = 1'b1;
                    n_state      = pba_pkg::S_A_RD;
                end
            end
            pba_pkg::S_A_BIT: begin
                cmd.bit_step = 1'b1;
                if (i_stat.bit_found) begin
                    cmd.alloc_hit = 1'b1;
                    n_state       = pba_pkg::S_M_RD;
                end else if (i_stat.bit_last) begin
                    if (i_stat.word_last) begin
                        cmd.set_norun = 1'b1;
                        n_state       = pba_pkg::S_RESP;
                    end else begin
                        cmd.widx_inc = 1'b1;
                        n_state      = pba_pkg::S_A_RD;
                    end
                end
            end
            pba_pkg::S_RESP: begin
                if (!r_out_valid || i_rsp_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = pba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_cmd       = cmd;
    assign o_rsp_valid = r_out_valid;

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == pba_pkg::S_DECODE))
        else $error("accepted request did not move to decode");

    a_rsp_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == pba_pkg::S_RESP))
        else $error("response raised outside the response state");

    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.rd_en && (cmd.wr_zero || cmd.wr_mask)))
        else $error("bitmap read and write in one cycle");

    a_boot_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pba_pkg::S_BOOT) |-> !o_req_ready)
        else $error("request taken during clearing pass");
endmodule

### hw/rtl/page_bitmap_allocator.sv
// Top level of the page bitmap allocator: controller, datapath and channel wiring.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------------
//  i_req    | in  | valid / ready | kind, start_address, end_address, byte_size
//  o_rsp    | out | valid / ready | available, result_address, status
//
//  One request at a time. A query reads one bitmap word; a bad or empty request goes
//  from decode straight to the response. A range mark or free reads, then writes, each
//  bitmap word touched. Allocate scans words over the single RAM port: a word that is
//  all used or wholly inside a run is handled whole, others bit by bit, then the run
//  is marked. Reset: a clearing pass writes all 2048 words before the first request;
//  a clear-all request takes the same sweep. A finished response waits in the output
//  register; the next request is accepted meanwhile and held at the end until it drains.

module page_bitmap_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pba_req_if.sink       i_req,
    pba_rsp_if.source     o_rsp
);
    pba_pkg::t_dp_cmd  cmd;
    pba_pkg::t_dp_stat stat;

    // Sequence each request: decode, sweep or scan the bitmap, then hand off the response.
    pba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Hold the request fields, the bitmap RAM and the response payload.
    pba_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_req.kind),
        .i_start_address  (i_req.start_address),
        .i_end_address    (i_req.end_address),
        .i_byte_size      (i_req.byte_size),
        .o_available      (o_rsp.available),
        .o_result_address (o_rsp.result_address),
        .o_status         (o_rsp.status)
    );
endmodule
